// ===== hdl/srcr_pkg.sv =====
// shared types and constants for the stereo ring cubic resampler
`default_nettype none

package srcr_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int PHASE_BITS     = 24;
   localparam int STEP_BITS      = PHASE_BITS + 2;
   localparam int RING_DEPTH_DEF = 4096;

   // horner accumulator: |v| stays below 22 * 2^(SAMPLE_BITS-1)
   localparam int ACC_BITS  = SAMPLE_BITS + 5;
   localparam int MAG_BITS  = ACC_BITS - 1;
   localparam int PROD_BITS = MAG_BITS + PHASE_BITS;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   localparam logic [STEP_BITS-1:0] STEP_RESET = {2'b01, {PHASE_BITS{1'b0}}};

   typedef struct packed {
      logic                          op;
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
   } req_type;

   typedef struct packed {
      logic                          valid_res;
      logic signed [SAMPLE_BITS-1:0] out_left;
      logic signed [SAMPLE_BITS-1:0] out_right;
   } rsp_type;

   typedef enum logic [1:0] {
      ADD_NONE = 2'd0,
      ADD_B    = 2'd1,
      ADD_C    = 2'd2
   } add_sel_type;

   typedef struct packed {
      logic        push;
      logic        pull_start;
      logic        rd_issue;
      logic [1:0]  rd_tap;
      logic        coef_load;
      logic        mul_go;
      logic        add_go;
      add_sel_type add_sel;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic fill_ge4;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/srcr_ctrl.sv =====
// sequencer for push, tap fetch, horner steps and result hand-off
`default_nettype none

module srcr_ctrl
   import srcr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_op,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_READ = 7'b0000010,
      ST_LAST = 7'b0000100,
      ST_COEF = 7'b0001000,
      ST_MUL  = 7'b0010000,
      ST_ADD  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   localparam logic [1:0] TAP_LAST    = 2'd3;
   localparam logic [1:0] HORNER_LAST = 2'd2;

   state_type  state_ff, state_in;
   logic [1:0] tap_ff, tap_in;
   logic [1:0] hstep_ff, hstep_in;

   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      hstep_in  = hstep_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OP_PUSH) begin
                  cmd.push = 1'b1;
               end else begin
                  cmd.pull_start = 1'b1;
                  tap_in         = 2'd0;
                  // short ring: answer with an empty result
                  state_in = stat.fill_ge4 ? ST_READ : ST_DONE;
               end
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_tap   = tap_ff;
            tap_in       = tap_ff + 2'd1;
            if (tap_ff == TAP_LAST) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_COEF;
         end
         ST_COEF: begin
            cmd.coef_load = 1'b1;
            hstep_in      = 2'd0;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_go = 1'b1;
            case (hstep_ff)
               2'd0:    cmd.add_sel = ADD_B;
               2'd1:    cmd.add_sel = ADD_C;
               default: cmd.add_sel = ADD_NONE;
            endcase
            hstep_in = hstep_ff + 2'd1;
            state_in = (hstep_ff == HORNER_LAST) ? ST_DONE : ST_MUL;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= 2'd0;
         hstep_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         hstep_ff <= hstep_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/srcr_dp.sv =====
// frame rings, pointers, phase, two-channel horner datapath and result register
`default_nettype none

module srcr_dp
   import srcr_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output stat_type                  stat,
   input  wire req_type              req_data,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [STEP_BITS-1:0] csr_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data
);

   localparam int IDX_BITS = $clog2(RING_DEPTH);
   localparam int CNT_BITS = $clog2(RING_DEPTH + 1);
   localparam logic [IDX_BITS:0]   DEPTH_X = (IDX_BITS + 1)'(RING_DEPTH);
   localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(RING_DEPTH);
   localparam logic [CNT_BITS-1:0] FOUR_C  = CNT_BITS'(4);
   localparam logic signed [SAMPLE_BITS:0] SAT_MAX =
      (SAMPLE_BITS + 1)'((2 ** (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SAMPLE_BITS:0] SAT_MIN = -SAT_MAX - 1;

   // ring positions stay below twice the depth
   function automatic logic [IDX_BITS-1:0] wrap(input logic [IDX_BITS:0] v);
      logic [IDX_BITS:0] w;
      w = (v >= DEPTH_X) ? v - DEPTH_X : v;
      return w[IDX_BITS-1:0];
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] finish_ch(
      input logic signed [SAMPLE_BITS-1:0] x1,
      input logic signed [ACC_BITS-1:0]    v
   );
      logic signed [ACC_BITS-1:0]    half;
      logic signed [ACC_BITS:0]      sum;
      logic signed [SAMPLE_BITS-1:0] r;
      // halve toward zero
      half = $signed(v + ACC_BITS'(v[ACC_BITS-1])) >>> 1;
      sum  = (ACC_BITS + 1)'(x1) + (ACC_BITS + 1)'(half);
      if (sum > (ACC_BITS + 1)'(SAT_MAX)) begin
         r = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (sum < (ACC_BITS + 1)'(SAT_MIN)) begin
         r = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         r = sum[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

   logic signed [SAMPLE_BITS-1:0] left_store_ff  [RING_DEPTH];
   logic signed [SAMPLE_BITS-1:0] right_store_ff [RING_DEPTH];

   logic [IDX_BITS-1:0]   oldest_ff;
   logic [CNT_BITS-1:0]   fill_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic                  res_ok_ff;
   logic                  rd_pend_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic signed [SAMPLE_BITS-1:0] rd_data_ff [2];
   logic signed [SAMPLE_BITS-1:0] tap_ff     [2][4];
   logic signed [ACC_BITS-1:0]    acc_ff     [2];
   logic signed [ACC_BITS-1:0]    cb_ff      [2];
   logic signed [ACC_BITS-1:0]    cc_ff      [2];
   logic [PROD_BITS-1:0]          prod_ff    [2];
   logic                          neg_ff     [2];

   logic [IDX_BITS-1:0]   wr_addr;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [PHASE_BITS+2:0] phase_sum;
   logic [2:0]            whole;

   assign wr_addr   = wrap({1'b0, oldest_ff} + (IDX_BITS + 1)'(fill_ff));
   assign rd_addr   = wrap({1'b0, oldest_ff} + (IDX_BITS + 1)'(cmd.rd_tap));
   assign phase_sum = (PHASE_BITS + 3)'(phase_ff) + (PHASE_BITS + 3)'(step_ff);
   assign whole     = phase_sum[PHASE_BITS+2:PHASE_BITS];

   assign stat.fill_ge4 = (fill_ff >= FOUR_C);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         left_store_ff[wr_addr]  <= req_data.left_sample;
         right_store_ff[wr_addr] <= req_data.right_sample;
      end
      rd_data_ff[0] <= left_store_ff[rd_addr];
      rd_data_ff[1] <= right_store_ff[rd_addr];
   end

   // ring pointers, phase and step
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         fill_ff   <= '0;
         phase_ff  <= '0;
         step_ff   <= STEP_RESET;
         res_ok_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            step_ff <= csr_data;
         end
         if (cmd.pull_start) begin
            res_ok_ff <= stat.fill_ge4;
         end
         if (cmd.push) begin
            if (fill_ff < DEPTH_C) begin
               fill_ff <= fill_ff + CNT_BITS'(1);
            end else begin
               oldest_ff <= wrap({1'b0, oldest_ff} + (IDX_BITS + 1)'(1));
            end
         end else if (cmd.finish && res_ok_ff) begin
            // a pull runs only with four or more frames, so whole never exceeds fill
            phase_ff  <= phase_sum[PHASE_BITS-1:0];
            oldest_ff <= wrap({1'b0, oldest_ff} + (IDX_BITS + 1)'(whole));
            fill_ff   <= fill_ff - CNT_BITS'(whole);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.rd_issue;
      end
   end

   // per-channel tap shift, coefficients and horner steps
   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 2; ch++) begin
         logic signed [ACC_BITS-1:0] x0, x1, x2, x3;
         logic [ACC_BITS-1:0]        mag;
         logic [MAG_BITS-1:0]        q;
         logic signed [ACC_BITS-1:0] sv;
         logic signed [ACC_BITS-1:0] addend;
         x0 = ACC_BITS'(tap_ff[ch][0]);
         x1 = ACC_BITS'(tap_ff[ch][1]);
         x2 = ACC_BITS'(tap_ff[ch][2]);
         x3 = ACC_BITS'(tap_ff[ch][3]);
         mag = acc_ff[ch][ACC_BITS-1] ? -acc_ff[ch] : acc_ff[ch];
         q   = prod_ff[ch][PHASE_BITS +: MAG_BITS];
         sv  = neg_ff[ch] ? -$signed({1'b0, q}) : $signed({1'b0, q});
         case (cmd.add_sel)
            ADD_B:   addend = cb_ff[ch];
            ADD_C:   addend = cc_ff[ch];
            default: addend = '0;
         endcase
         if (rd_pend_ff) begin
            tap_ff[ch][0] <= tap_ff[ch][1];
            tap_ff[ch][1] <= tap_ff[ch][2];
            tap_ff[ch][2] <= tap_ff[ch][3];
            tap_ff[ch][3] <= rd_data_ff[ch];
         end
         if (cmd.coef_load) begin
            // doubled catmull-rom coefficients
            acc_ff[ch] <= ACC_BITS'(-x0 + 3 * x1 - 3 * x2 + x3);
            cb_ff[ch]  <= ACC_BITS'(2 * x0 - 5 * x1 + 4 * x2 - x3);
            cc_ff[ch]  <= x2 - x0;
         end else if (cmd.add_go) begin
            acc_ff[ch] <= sv + addend;
         end
         if (cmd.mul_go) begin
            prod_ff[ch] <= PROD_BITS'(mag[MAG_BITS-1:0]) * PROD_BITS'(phase_ff);
            neg_ff[ch]  <= acc_ff[ch][ACC_BITS-1];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (res_ok_ff) begin
            rsp_data_ff.valid_res <= 1'b1;
            rsp_data_ff.out_left  <= finish_ch(tap_ff[0][1], acc_ff[0]);
            rsp_data_ff.out_right <= finish_ch(tap_ff[1][1], acc_ff[1]);
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/stereo_ring_cubic_resampler.sv =====
// Stereo frame ring with a Catmull-Rom fractional-step resampler. A push request stores one
// left/right frame without leaving the idle state, dropping the oldest frame once the ring
// of RING_DEPTH frames is full. A pull request returns one result: with fewer than four
// frames stored it answers valid_res 0 and zero samples without fetching taps; otherwise it
// interpolates both channels over the four oldest frames at the current Q0.24 phase,
// saturates to 24 bits, then adds the Q2.24 step and drops one frame per whole unit crossed.
// A pull fetches the taps one at a time through the shared ring read address, whose read is
// registered, loads the coefficients, runs each Horner step as a multiply then an add on the
// per-channel multiplier and loads the result register once the previous result is taken;
// the input is held throughout, and no further request is taken until that load. The result
// waits in the register for rsp_ready while pushes go on. The step register resets to 1.0;
// the user must write it through csr_valid/csr_data only while the block is idle, as the block does not enforce this.
`default_nettype none

module stereo_ring_cubic_resampler
   import srcr_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [STEP_BITS-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   srcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   srcr_dp #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hdl/srcr_checker.sv =====
// port-level checks for the stereo ring cubic resampler
`default_nettype none

module srcr_checker
   import srcr_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a push request finishes in its own cycle
   a_push_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op == OP_PUSH |=> req_ready)
      else $error("push request held the block");

   // a pull request occupies the block
   a_pull_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op == OP_PULL |=> !req_ready)
      else $error("request taken during a pull");

   // an empty result carries zero samples
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |-> rsp_data.out_left == '0 && rsp_data.out_right == '0)
      else $error("empty result with nonzero samples");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind stereo_ring_cubic_resampler srcr_checker u_srcr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
